// ===== rtl/acnm_pkg.sv =====
// Shared types, constants and helper functions for the nonlinear channel mixer.
// Used by acnm_ctrl, acnm_dp, the top level and the assertion checker.
package acnm_pkg;

    // Fixed field widths.
    localparam int CH_BITS    = 4;
    localparam int STAMP_W    = 16;
    localparam int DELTA_W    = 16;
    localparam int OUT_DW     = 19;
    localparam int SILENT_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 88;

    // Default parameter values.
    localparam int DEF_CHANNELS   = 11;
    localparam int DEF_STAMP_BITS = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MVOL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GW_LO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GW_MID = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GW_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO = 3'd5;

    // Input command and output kind codes.
    localparam logic CMD_DELTA = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    // Curve constants: q = K*x / (C + 100*x).
    localparam logic [19:0] K_SQ  = 20'd479400;
    localparam logic [19:0] K_TND = 20'd798950;
    localparam logic [38:0] C_SQ  = 39'd133169152;
    localparam logic [38:0] C_TND = 39'd379802615808;

    // Quotient bits of the curve division (both quotients stay below 8192).
    localparam int Q_BITS = 13;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LV,
        OP_WF,
        OP_MW,
        OP_ADD,
        OP_NHI,
        OP_NLO,
        OP_NSUM,
        OP_DIV,
        OP_QST,
        OP_MIX,
        OP_GAIN,
        OP_SCALE,
        OP_RES
    } t_op;

    // Command from the controller to the datapath.
    typedef struct packed {
        t_op                op;
        logic [CH_BITS-1:0] ch;
        logic               grp;       // 0 squares, 1 triangle/noise/DMC
        logic               side;      // 0 left, 1 right
        logic               accept;    // input item taken this cycle
        logic               load_out;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stereo;
        logic out_busy;
    } t_stat;

    // Volume (low byte) and pan (high byte) of one channel.
    function automatic logic [15:0] chan_gain(input logic [CH_BITS-1:0] ch,
                                              input logic [63:0] lo,
                                              input logic [63:0] mid,
                                              input logic [47:0] hi);
        logic [63:0] word;
        logic [15:0] g;
        case (ch[3:2])
            2'd0:    word = lo;
            2'd1:    word = mid;
            default: word = {16'd0, hi};
        endcase
        case (ch[1:0])
            2'd0:    g = word[15:0];
            2'd1:    g = word[31:16];
            2'd2:    g = word[47:32];
            default: g = word[63:48];
        endcase
        return g;
    endfunction

    // Fixed weight of each channel within its group.
    function automatic logic [12:0] chan_weight(input logic [CH_BITS-1:0] ch);
        logic [12:0] w;
        case (ch)
            4'd0, 4'd1: w = 13'd1;
            4'd2:       w = 13'd2818;
            4'd3:       w = 13'd1894;
            4'd4:       w = 13'd1123;
            4'd5:       w = 13'd20;
            4'd6:       w = 13'd43;
            4'd7:       w = 13'd48;
            4'd8:       w = 13'd1;
            4'd9:       w = 13'd20;
            4'd10:      w = 13'd15;
            default:    w = 13'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/apu_channel_nonlinear_mixer.sv =====
// Top level of the nonlinear stereo channel mixer: stream ports, controller
// and datapath. Depends on acnm_pkg, acnm_ctrl and acnm_dp.
//
//  port group   direction  handshake                   payload
//  s_axis       in         s_axis_tvalid/tready        tdata, tuser=command, tlast
//  m_axis       out        m_axis_tvalid/tready        tdata, tuser=kind
//  cfg          in         i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
// An unmarked delta adds to its pending sum and yields no result. A marked delta
// runs the channel loop on the single shared multiplier (four steps per channel)
// and the 13-step divider for both curves, once per side in stereo. A frame end
// goes to the output register without computation. One item is processed at a
// time; the output register lets the next item in while a result waits. Reset is synchronous.
module apu_channel_nonlinear_mixer #(
    parameter int CHANNELS   = acnm_pkg::DEF_CHANNELS,
    parameter int STAMP_BITS = acnm_pkg::DEF_STAMP_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // channel[3:0], stamp[19:4], level_delta[35:20], zero fill above
    input  logic [acnm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // command
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_stamp[15:0], left_delta[34:16], right_delta[53:35],
    // silent_frames[85:54], zero fill above
    output logic [acnm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // kind
    output logic                                 m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [acnm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [acnm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    acnm_pkg::t_cmd  w_cmd;
    acnm_pkg::t_stat w_stat;
    logic [acnm_pkg::STAMP_W-1:0]       w_ostamp;
    logic signed [acnm_pkg::OUT_DW-1:0] w_oleft, w_oright;
    logic [acnm_pkg::SILENT_W-1:0]      w_osilent;

    assign o_cfg_ready = 1'b1;

    acnm_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    acnm_dp #(
        .CHANNELS   (CHANNELS),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_in_cmd     (s_axis_tuser),
        .i_in_ch      (s_axis_tdata[3:0]),
        .i_in_stamp   (s_axis_tdata[19:4]),
        .i_in_delta   ($signed(s_axis_tdata[35:20])),
        .i_in_last    (s_axis_tlast),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_kind   (m_axis_tuser),
        .o_out_stamp  (w_ostamp),
        .o_out_left   (w_oleft),
        .o_out_right  (w_oright),
        .o_out_silent (w_osilent)
    );

    assign m_axis_tdata = {2'd0, w_osilent, w_oright, w_oleft, w_ostamp};

endmodule

// ===== rtl/acnm_ctrl.sv =====
// Sequencer of the nonlinear channel mixer: steps the datapath through the
// channel loop, the two curve divisions and the output scaling. Uses acnm_pkg.
module acnm_ctrl #(
    parameter int CHANNELS = acnm_pkg::DEF_CHANNELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  acnm_pkg::t_stat   i_stat,
    output acnm_pkg::t_cmd    o_cmd
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);
    localparam logic [3:0] DIV_LAST = 4'(acnm_pkg::Q_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LV, S_WF, S_MW, S_ADD, S_NHI, S_NLO, S_NSUM,
        S_DIV, S_QST, S_MIX, S_GAIN, S_SCALE, S_RES, S_EMIT
    } t_state;

    t_state          r_state;
    logic [CH_W-1:0] r_ch;
    logic            r_grp;
    logic            r_side;
    logic [3:0]      r_cnt;
    logic            w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Command decode from the current state.
    always_comb begin
        o_cmd          = '0;
        o_cmd.ch       = acnm_pkg::CH_BITS'(r_ch);
        o_cmd.grp      = r_grp;
        o_cmd.side     = r_side;
        o_cmd.accept   = w_accept;
        o_cmd.load_out = (r_state == S_EMIT) && !i_stat.out_busy;
        unique case (r_state)
            S_LV:    o_cmd.op = acnm_pkg::OP_LV;
            S_WF:    o_cmd.op = acnm_pkg::OP_WF;
            S_MW:    o_cmd.op = acnm_pkg::OP_MW;
            S_ADD:   o_cmd.op = acnm_pkg::OP_ADD;
            S_NHI:   o_cmd.op = acnm_pkg::OP_NHI;
            S_NLO:   o_cmd.op = acnm_pkg::OP_NLO;
            S_NSUM:  o_cmd.op = acnm_pkg::OP_NSUM;
            S_DIV:   o_cmd.op = acnm_pkg::OP_DIV;
            S_QST:   o_cmd.op = acnm_pkg::OP_QST;
            S_MIX:   o_cmd.op = acnm_pkg::OP_MIX;
            S_GAIN:  o_cmd.op = acnm_pkg::OP_GAIN;
            S_SCALE: o_cmd.op = acnm_pkg::OP_SCALE;
            S_RES:   o_cmd.op = acnm_pkg::OP_RES;
            default: o_cmd.op = acnm_pkg::OP_NONE;
        endcase
    end

    // State register and loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
            r_grp   <= 1'b0;
            r_side  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ch   <= '0;
                        r_grp  <= 1'b0;
                        r_side <= 1'b0;
                        if (i_in_cmd == acnm_pkg::CMD_FRAME) begin
                            r_state <= S_EMIT;
                        end else if (i_in_last) begin
                            r_state <= S_LV;
                        end
                    end
                end
                S_LV:  r_state <= S_WF;
                S_WF:  r_state <= S_MW;
                S_MW:  r_state <= S_ADD;
                S_ADD: begin
                    if (r_ch == CH_LAST) begin
                        r_ch    <= '0;
                        r_grp   <= 1'b0;
                        r_state <= S_NHI;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_LV;
                    end
                end
                S_NHI:  r_state <= S_NLO;
                S_NLO:  r_state <= S_NSUM;
                S_NSUM: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_QST;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_QST: begin
                    if (!r_grp) begin
                        r_grp   <= 1'b1;
                        r_state <= S_NHI;
                    end else begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX:   r_state <= S_GAIN;
                S_GAIN:  r_state <= S_SCALE;
                S_SCALE: r_state <= S_RES;
                S_RES: begin
                    if (!r_side && i_stat.stereo) begin
                        r_side  <= 1'b1;
                        r_ch    <= '0;
                        r_state <= S_LV;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!i_stat.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/acnm_dp.sv =====
// Datapath of the nonlinear channel mixer: configuration registers, channel
// levels, shared multiplier, curve divider and output register. Uses acnm_pkg.
module acnm_dp #(
    parameter int CHANNELS   = acnm_pkg::DEF_CHANNELS,
    parameter int STAMP_BITS = acnm_pkg::DEF_STAMP_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  acnm_pkg::t_cmd                        i_cmd,
    output acnm_pkg::t_stat                       o_stat,
    input  logic                                  i_in_cmd,
    input  logic [acnm_pkg::CH_BITS-1:0]          i_in_ch,
    input  logic [acnm_pkg::STAMP_W-1:0]          i_in_stamp,
    input  logic signed [acnm_pkg::DELTA_W-1:0]   i_in_delta,
    input  logic                                  i_in_last,
    input  logic                                  i_cfg_valid,
    input  logic [acnm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [acnm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic                                  o_out_kind,
    output logic [acnm_pkg::STAMP_W-1:0]          o_out_stamp,
    output logic signed [acnm_pkg::OUT_DW-1:0]    o_out_left,
    output logic signed [acnm_pkg::OUT_DW-1:0]    o_out_right,
    output logic [acnm_pkg::SILENT_W-1:0]         o_out_silent
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW   = (STAMP_BITS < acnm_pkg::STAMP_W) ? STAMP_BITS : acnm_pkg::STAMP_W;

    // Configuration registers.
    logic [9:0]  r_mvol;
    logic [8:0]  r_fade;
    logic [63:0] r_gw_lo;
    logic [63:0] r_gw_mid;
    logic [47:0] r_gw_hi;
    logic        r_stereo;

    // Channel state.
    logic signed [15:0] r_lvl  [CHANNELS];
    logic signed [16:0] r_pend [CHANNELS];
    logic [31:0]        r_silent;
    logic               r_quiet;

    // Working registers.
    logic signed [57:0] r_prod;
    logic signed [47:0] r_s, r_t, r_e;
    logic [63:0]        r_num;
    logic [52:0]        r_den;
    logic [52:0]        r_rem;
    logic [12:0]        r_nlo;
    logic [12:0]        r_q;
    logic               r_pos;
    logic [12:0]        r_sq, r_tnd;
    logic signed [15:0] r_prev_l, r_prev_r;
    logic signed [16:0] r_diff;
    logic signed [18:0] r_dl, r_dr;
    logic               r_kind;
    logic [SW-1:0]      r_stamp;

    // Output register.
    logic               r_oval;
    logic               r_okind;
    logic [SW-1:0]      r_ostamp;
    logic signed [18:0] r_oleft, r_oright;
    logic [31:0]        r_osilent;

    assign o_stat.stereo   = r_stereo;
    assign o_stat.out_busy = r_oval && !i_out_ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvol   <= 10'd256;
            r_fade   <= 9'd256;
            r_gw_lo  <= '0;
            r_gw_mid <= '0;
            r_gw_hi  <= '0;
            r_stereo <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                acnm_pkg::REG_MVOL:   r_mvol   <= i_cfg_data[9:0];
                acnm_pkg::REG_FADE:   r_fade   <= i_cfg_data[8:0];
                acnm_pkg::REG_GW_LO:  r_gw_lo  <= i_cfg_data;
                acnm_pkg::REG_GW_MID: r_gw_mid <= i_cfg_data;
                acnm_pkg::REG_GW_HI:  r_gw_hi  <= i_cfg_data[47:0];
                acnm_pkg::REG_STEREO: r_stereo <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pending sum of the addressed channel, and the levels after applying it.
    logic               w_in_range;
    logic [CH_W-1:0]    w_in_idx;
    logic signed [17:0] w_pend_sum;
    logic signed [16:0] w_pend_new;
    logic signed [16:0] w_eff   [CHANNELS];
    logic signed [15:0] w_lvl_nx[CHANNELS];
    logic               w_any;

    always_comb begin
        logic signed [17:0] t;
        w_in_range = (32'(i_in_ch) < CHANNELS);
        w_in_idx   = CH_W'(i_in_ch);
        w_pend_sum = 18'(r_pend[w_in_idx]) + 18'(i_in_delta);
        if (w_pend_sum > 18'sd65535) begin
            w_pend_new = 17'sd65535;
        end else if (w_pend_sum < -18'sd65536) begin
            w_pend_new = -17'sd65536;
        end else begin
            w_pend_new = w_pend_sum[16:0];
        end
        w_any = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            w_eff[i] = (w_in_range && (32'(w_in_idx) == i)) ? w_pend_new : r_pend[i];
            t = 18'(r_lvl[i]) + 18'(w_eff[i]);
            if (t > 18'sd32767) begin
                w_lvl_nx[i] = 16'sd32767;
            end else if (t < -18'sd32768) begin
                w_lvl_nx[i] = -16'sd32768;
            end else begin
                w_lvl_nx[i] = t[15:0];
            end
            if (w_eff[i] != 17'sd0) begin
                w_any = 1'b1;
            end
        end
    end

    // Channel levels, pending sums and silence tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_lvl[i]  <= '0;
                r_pend[i] <= '0;
            end
            r_silent <= '0;
            r_quiet  <= 1'b1;
        end else if (i_cmd.accept) begin
            if (i_in_cmd == acnm_pkg::CMD_FRAME) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_pend[i] <= '0;
                end
                if (!r_quiet) begin
                    r_silent <= '0;
                end else if (r_silent != 32'hFFFF_FFFF) begin
                    r_silent <= r_silent + 1'b1;
                end
                r_quiet <= 1'b1;
            end else if (i_in_last) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_lvl[i]  <= w_lvl_nx[i];
                    r_pend[i] <= '0;
                end
                if (w_any) begin
                    r_quiet <= 1'b0;
                end
            end else if (w_in_range) begin
                r_pend[w_in_idx] <= w_pend_new;
            end
        end
    end

    // Shared multiplier operand selection.
    logic [15:0]        w_gain;
    logic [8:0]         w_f;
    logic signed [47:0] w_x;
    logic [19:0]        w_k;
    logic [38:0]        w_c;
    logic signed [33:0] w_mul_a;
    logic signed [23:0] w_mul_b;
    logic signed [57:0] w_prod;

    always_comb begin
        w_gain = acnm_pkg::chan_gain(i_cmd.ch, r_gw_lo, r_gw_mid, r_gw_hi);
        w_f    = i_cmd.side ? {1'b0, w_gain[15:8]} : (9'd256 - {1'b0, w_gain[15:8]});
        w_x    = i_cmd.grp ? r_t : r_s;
        w_k    = i_cmd.grp ? acnm_pkg::K_TND : acnm_pkg::K_SQ;
        w_c    = i_cmd.grp ? acnm_pkg::C_TND : acnm_pkg::C_SQ;
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            acnm_pkg::OP_LV: begin
                w_mul_a = 34'(r_lvl[i_cmd.ch[CH_W-1:0]]);
                w_mul_b = $signed({16'd0, w_gain[7:0]});
            end
            acnm_pkg::OP_WF: begin
                w_mul_a = r_prod[33:0];
                w_mul_b = $signed({15'd0, w_f});
            end
            acnm_pkg::OP_MW: begin
                w_mul_a = r_prod[33:0];
                w_mul_b = $signed({11'd0, acnm_pkg::chan_weight(i_cmd.ch)});
            end
            acnm_pkg::OP_NHI: begin
                w_mul_a = $signed({9'd0, w_x[47:23]});
                w_mul_b = $signed({4'd0, w_k});
            end
            acnm_pkg::OP_NLO: begin
                w_mul_a = $signed({11'd0, w_x[22:0]});
                w_mul_b = $signed({4'd0, w_k});
            end
            acnm_pkg::OP_GAIN: begin
                w_mul_a = $signed({24'd0, r_mvol});
                w_mul_b = $signed({15'd0, r_fade});
            end
            acnm_pkg::OP_SCALE: begin
                w_mul_a = 34'(r_diff);
                w_mul_b = r_prod[23:0];
            end
            default: ;
        endcase
        w_prod = 58'(w_mul_a) * 58'(w_mul_b);
    end

    // Curve denominator, division step, mix and scaled delta.
    logic [53:0]        w_den;
    logic [63:0]        w_num_sum;
    logic [52:0]        w_trial;
    logic signed [47:0] w_total;
    logic signed [33:0] w_trunc;
    logic signed [15:0] w_cur;
    logic signed [16:0] w_diff;
    logic signed [41:0] w_scaled;
    logic signed [18:0] w_res;

    always_comb begin
        logic [53:0] xu;
        xu        = {6'd0, w_x};
        w_den     = 54'(w_c) + (xu << 6) + (xu << 5) + (xu << 2);
        w_num_sum = r_num + 64'(unsigned'(r_prod));
        w_trial   = {r_rem[51:0], r_nlo[12]};

        // The two curve outputs together can exceed 13 bits.
        w_total = $signed({20'd0, 14'(r_sq) + 14'(r_tnd), 14'd0}) + r_e;
        w_trunc = 34'(w_total >>> 14) + 34'((w_total[47] && (|w_total[13:0])) ? 1 : 0);
        if (w_trunc > 34'sd32767) begin
            w_cur = 16'sd32767;
        end else if (w_trunc < -34'sd32768) begin
            w_cur = -16'sd32768;
        end else begin
            w_cur = w_trunc[15:0];
        end
        w_diff = 17'(w_cur) - 17'(i_cmd.side ? r_prev_r : r_prev_l);

        w_scaled = 42'(r_prod >>> 16) + 42'((r_prod[57] && (|r_prod[15:0])) ? 1 : 0);
        if (w_scaled > 42'sd262143) begin
            w_res = 19'sd262143;
        end else if (w_scaled < -42'sd262144) begin
            w_res = -19'sd262144;
        end else begin
            w_res = w_scaled[18:0];
        end
    end

    // Working registers, sequenced by the controller.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_in_cmd;
            r_stamp <= i_in_stamp[SW-1:0];
            if (i_in_cmd == acnm_pkg::CMD_FRAME) begin
                r_dl <= '0;
                r_dr <= '0;
            end
        end
        case (i_cmd.op)
            acnm_pkg::OP_LV: begin
                r_prod <= w_prod;
                if (i_cmd.ch == '0) begin
                    r_s <= '0;
                    r_t <= '0;
                    r_e <= '0;
                end
            end
            acnm_pkg::OP_WF, acnm_pkg::OP_MW, acnm_pkg::OP_NHI,
            acnm_pkg::OP_GAIN, acnm_pkg::OP_SCALE: begin
                r_prod <= w_prod;
            end
            acnm_pkg::OP_ADD: begin
                if (i_cmd.ch < 4'd2) begin
                    r_s <= r_s + r_prod[47:0];
                end else if (i_cmd.ch < 4'd5) begin
                    r_t <= r_t + r_prod[47:0];
                end else begin
                    r_e <= r_e + r_prod[47:0];
                end
            end
            acnm_pkg::OP_NLO: begin
                r_num  <= {r_prod[40:0], 23'd0};
                r_prod <= w_prod;
                r_den  <= w_den[52:0];
                r_pos  <= !w_x[47] && (w_x != '0);
            end
            acnm_pkg::OP_NSUM: begin
                r_rem <= {2'd0, w_num_sum[63:13]};
                r_nlo <= w_num_sum[12:0];
                r_q   <= '0;
            end
            acnm_pkg::OP_DIV: begin
                if (w_trial >= r_den) begin
                    r_rem <= w_trial - r_den;
                    r_q   <= {r_q[11:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[11:0], 1'b0};
                end
                r_nlo <= {r_nlo[11:0], 1'b0};
            end
            acnm_pkg::OP_QST: begin
                if (i_cmd.grp) begin
                    r_tnd <= r_pos ? r_q : '0;
                end else begin
                    r_sq  <= r_pos ? r_q : '0;
                end
            end
            acnm_pkg::OP_MIX: begin
                r_diff <= w_diff;
            end
            acnm_pkg::OP_RES: begin
                r_dl <= i_cmd.side ? r_dl : w_res;
                r_dr <= w_res;
            end
            default: ;
        endcase
    end

    // Previous mix values per side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_l <= '0;
            r_prev_r <= '0;
        end else if (i_cmd.op == acnm_pkg::OP_MIX) begin
            if (i_cmd.side) begin
                r_prev_r <= w_cur;
            end else begin
                r_prev_l <= w_cur;
            end
        end
    end

    // Output register: holds a finished item until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_oval <= 1'b1;
        end else if (i_out_ready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_okind   <= r_kind;
            r_ostamp  <= r_stamp;
            r_oleft   <= r_dl;
            r_oright  <= r_dr;
            r_osilent <= r_silent;
        end
    end

    assign o_out_valid  = r_oval;
    assign o_out_kind   = r_okind;
    assign o_out_stamp  = acnm_pkg::STAMP_W'(r_ostamp);
    assign o_out_left   = r_oleft;
    assign o_out_right  = r_oright;
    assign o_out_silent = r_osilent;

endmodule

// ===== rtl/acnm_chk.sv =====
// Port-level assertions for the nonlinear channel mixer, bound to the top level.
// Depends on acnm_pkg and apu_channel_nonlinear_mixer.
module acnm_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [acnm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                              s_axis_tuser,
    input logic                              s_axis_tlast,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [acnm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tuser,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [acnm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [acnm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // A frame end item carries no mix change.
    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == acnm_pkg::CMD_FRAME))
            |-> (m_axis_tdata[53:16] == '0))
        else $error("frame end item with nonzero deltas");

    // No result is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Once a frame end input is accepted, the input is not ready in the next cycle.
    a_frame_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == acnm_pkg::CMD_FRAME))
            |=> !s_axis_tready)
        else $error("input taken while a frame end is pending");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output item changed");

endmodule

bind apu_channel_nonlinear_mixer acnm_chk u_acnm_chk (.*);

// ===== bench/tb.sv =====
// Self-checking bench for the nonlinear stereo channel mixer: drives delta and frame-end items,
// predicts each mix and frame result or takes it from the directed table, and compares them field by field.
// Depends on acnm_pkg and apu_channel_nonlinear_mixer.
module tb;

    localparam int NCH = 11;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [acnm_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd6;

    // One expected output item.
    typedef struct {
        logic        kind;
        logic [15:0] stamp;
        logic [18:0] left;
        logic [18:0] right;
        logic [31:0] silent;
    } t_mix_result;

    // One row of the directed table.
    typedef struct {
        logic        cmd;
        logic [3:0]  ch;
        logic [15:0] stamp;
        logic [15:0] delta;
        logic        last;
        bit          typed;
        logic [31:0] silent;
    } t_stim_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [acnm_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [acnm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [acnm_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [acnm_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    apu_channel_nonlinear_mixer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the registers and mixer state.
    int unsigned     mvol = 256;
    int unsigned     fade = 256;
    logic [63:0]     gain_lo = '0;
    logic [63:0]     gain_mid = '0;
    logic [47:0]     gain_hi = '0;
    bit              stereo = 1'b0;
    int              level[NCH];
    int              pending[NCH];
    int              last_left = 0;
    int              last_right = 0;
    int unsigned     silent_cnt = 0;
    bit              quiet = 1'b1;

    t_mix_result     result_q[$];
    int              errors = 0;
    int              mix_seen = 0;
    int              frame_seen = 0;
    int              items_sent = 0;
    bit              no_idle = 1'b0;
    bit              hold_req = 1'b0;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Channel level times volume times pan factor, in Q.14.
    function automatic longint weighted_level(int ch, bit rt);
        logic [63:0] word;
        logic [15:0] g;
        longint      f;
        if (ch >= NCH) return 0;
        word = ch < 4 ? gain_lo : (ch < 8 ? gain_mid : {16'd0, gain_hi});
        g = 16'(word >> ((ch % 4) * 16));
        f = rt ? longint'(g[15:8]) : 256 - longint'(g[15:8]);
        return longint'(level[ch]) * longint'(g[7:0]) * f;
    endfunction

    // Mix of one side after the nonlinear curves, saturated to 16 bits.
    function automatic int mix_level(bit rt);
        longint          s, t, e, total;
        longint unsigned sq, tnd;
        s = weighted_level(0, rt) + weighted_level(1, rt);
        t = 2818 * weighted_level(2, rt) + 1894 * weighted_level(3, rt)
            + 1123 * weighted_level(4, rt);
        e = 20 * weighted_level(5, rt) + 43 * weighted_level(6, rt) + 48 * weighted_level(7, rt)
            + weighted_level(8, rt) + 20 * weighted_level(9, rt) + 15 * weighted_level(10, rt);
        sq = 0;
        tnd = 0;
        if (s > 0) sq = (64'd479400 * 64'(s)) / (64'd133169152 + 64'd100 * 64'(s));
        if (t > 0) tnd = (64'd798950 * 64'(t)) / (64'd379802615808 + 64'd100 * 64'(t));
        total = longint'(sq + tnd) * 16384 + e;
        return int'(clamp(total / 16384, -32768, 32767));
    endfunction

    function automatic logic [18:0] scaled_step(int cur, int prev);
        longint p;
        p = longint'(cur - prev) * longint'(mvol) * longint'(fade);
        return 19'(clamp(p / 65536, -262144, 262143));
    endfunction

    // Updates the predictor state for one accepted item; returns 1 if it yields a result.
    function automatic bit predict_mixer(logic cmd, logic [3:0] ch, logic [15:0] stamp,
                                         logic [15:0] delta, logic last,
                                         output t_mix_result r);
        int cur;
        r.kind = cmd;
        r.stamp = stamp;
        r.left = '0;
        r.right = '0;
        if (cmd == acnm_pkg::CMD_FRAME) begin
            if (quiet) begin
                if (silent_cnt != 32'hFFFF_FFFF) silent_cnt++;
            end else begin
                silent_cnt = 0;
            end
            quiet = 1'b1;
            foreach (pending[i]) pending[i] = 0;
            r.silent = silent_cnt;
            return 1'b1;
        end
        if (ch < NCH)
            pending[ch] = int'(clamp(pending[ch] + int'($signed(delta)), -65536, 65535));
        if (!last) return 1'b0;
        foreach (level[i]) begin
            if (pending[i] != 0) quiet = 1'b0;
            level[i] = int'(clamp(level[i] + pending[i], -32768, 32767));
            pending[i] = 0;
        end
        cur = mix_level(1'b0);
        r.left = scaled_step(cur, last_left);
        last_left = cur;
        if (stereo) begin
            cur = mix_level(1'b1);
            r.right = scaled_step(cur, last_right);
            last_right = cur;
        end else begin
            r.right = r.left;
        end
        r.silent = silent_cnt;
        return 1'b1;
    endfunction

    // Offers one item after a random gap and records its expectation on acceptance.
    task automatic send_item(logic cmd, logic [3:0] ch, logic [15:0] stamp,
                             logic [15:0] delta, logic last,
                             bit typed = 1'b0, logic [31:0] typed_silent = '0);
        int          gap;
        t_mix_result r;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, delta, stamp, ch};
        s_axis_tuser <= cmd;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (predict_mixer(cmd, ch, stamp, delta, last, r)) begin
            if (typed) begin
                r.left = '0;
                r.right = '0;
                r.silent = typed_silent;
            end
            result_q.insert(result_q.size(), r);
        end
    endtask

    // Waits until every expected result has come and the block has settled.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [acnm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            acnm_pkg::REG_MVOL:   mvol = 32'(data[9:0]);
            acnm_pkg::REG_FADE:   fade = 32'(data[8:0]);
            acnm_pkg::REG_GW_LO:  gain_lo = data;
            acnm_pkg::REG_GW_MID: gain_mid = data;
            acnm_pkg::REG_GW_HI:  gain_hi = data[47:0];
            acnm_pkg::REG_STEREO: stereo = data[0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [9:0] mv, logic [8:0] fd, logic [63:0] lo,
                             logic [63:0] mid, logic [47:0] hi, bit st);
        write_reg(acnm_pkg::REG_MVOL, 64'(mv));
        write_reg(acnm_pkg::REG_FADE, 64'(fd));
        write_reg(acnm_pkg::REG_GW_LO, lo);
        write_reg(acnm_pkg::REG_GW_MID, mid);
        write_reg(acnm_pkg::REG_GW_HI, {16'd0, hi});
        write_reg(acnm_pkg::REG_STEREO, 64'(st));
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_delta();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 4000)) - 2000);
    endfunction

    // Receiver: random stalls per item, plus one long hold-off on request.
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 16);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Output checker: each accepted item against the oldest expectation.
    always @(posedge i_clk) begin
        t_mix_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected output item %h", m_axis_tdata);
            end else begin
                e = result_q.pop_front();
                if (m_axis_tuser) frame_seen++; else mix_seen++;
                if (m_axis_tuser !== e.kind || m_axis_tdata[15:0] !== e.stamp
                    || m_axis_tdata[34:16] !== e.left || m_axis_tdata[53:35] !== e.right
                    || m_axis_tdata[85:54] !== e.silent) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Mismatch: expected kind %0b stamp %0d L %h R %h silent %0d",
                                 e.kind, e.stamp, e.left, e.right, e.silent);
                        $display("          got kind %0b stamp %0d L %h R %h silent %0d",
                                 m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[34:16],
                                 m_axis_tdata[53:35], m_axis_tdata[85:54]);
                    end
                end
            end
        end
    end

    // Run limit.
    initial begin
        #20000000;
        $display("Timeout waiting for the mixer");
        $display("Simulation FAILED");
        $finish;
    end

    // Main stimulus.
    initial begin
        t_stim_row   rows[$];
        t_stim_row   row;
        int          ph, n, k, pick;
        logic [16:0] stamp;
        logic [3:0]  ch;
        bit          held;
        held = 1'b0;
        foreach (level[i]) begin
            level[i] = 0;
            pending[i] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with reset gains: every mix is zero, silence counting is visible.
        rows.insert(rows.size(), '{acnm_pkg::CMD_FRAME, 4'd0, 16'd0, 16'd0, 1'b0, 1'b1, 32'd1});
        rows.insert(rows.size(),
                    '{acnm_pkg::CMD_DELTA, 4'd0, 16'd10, 16'h7FFF, 1'b0, 1'b0, 32'd0});
        rows.insert(rows.size(),
                    '{acnm_pkg::CMD_DELTA, 4'd0, 16'd10, 16'h7FFF, 1'b1, 1'b1, 32'd1});
        rows.insert(rows.size(),
                    '{acnm_pkg::CMD_FRAME, 4'd0, 16'd200, 16'd0, 1'b0, 1'b1, 32'd0});
        rows.insert(rows.size(),
                    '{acnm_pkg::CMD_DELTA, 4'd15, 16'hFFFF, 16'h8000, 1'b1, 1'b1, 32'd0});
        rows.insert(rows.size(),
                    '{acnm_pkg::CMD_FRAME, 4'd0, 16'hFFFF, 16'd0, 1'b0, 1'b1, 32'd1});
        // Unmarked delta dropped at frame end does not break silence.
        rows.insert(rows.size(),
                    '{acnm_pkg::CMD_DELTA, 4'd3, 16'd5, 16'h8000, 1'b0, 1'b0, 32'd0});
        rows.insert(rows.size(), '{acnm_pkg::CMD_FRAME, 4'd0, 16'd9, 16'd0, 1'b0, 1'b1, 32'd2});
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].ch, rows[i].stamp, rows[i].delta, rows[i].last,
                      rows[i].typed, rows[i].silent);
        wait_drained();

        // Full gains and stereo: every channel at a level extreme, checked by prediction.
        write_all(10'd1023, 9'd256, '1, '1, '1, 1'b1);
        rows.delete();
        for (k = 0; k < NCH; k++) begin
            row = '{acnm_pkg::CMD_DELTA, 4'(k), 16'(20 * k + 20),
                    (k % 2) ? 16'h8000 : 16'h7FFF, 1'b1, 1'b0, 32'd0};
            rows.insert(rows.size(), row);
        end
        rows.insert(rows.size(),
                    '{acnm_pkg::CMD_FRAME, 4'd0, 16'd400, 16'd0, 1'b0, 1'b0, 32'd0});
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].ch, rows[i].stamp, rows[i].delta, rows[i].last);
        wait_drained();

        // Random phases, each under its own register setting.
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_all(10'd256, 9'd256, rand_word(), rand_word(), 48'(rand_word()), 1'b0);
                1: write_all(10'd1023, 9'd256, '1, '1, '1, 1'b1);
                2: write_all(10'd0, 9'd0, rand_word(), rand_word(), 48'(rand_word()), 1'b1);
                3: write_all(10'($urandom), 9'($urandom_range(0, 256)), rand_word(),
                             rand_word(), 48'(rand_word()), 1'($urandom));
                4: write_all(10'd1023, 9'($urandom_range(0, 256)), rand_word(), rand_word(),
                             48'(rand_word()), 1'b1);
                default: write_all(10'($urandom), 9'($urandom_range(0, 256)), rand_word(),
                                   rand_word(), 48'(rand_word()), 1'($urandom));
            endcase
            if (ph == 2) write_reg(REG_SPARE, rand_word());
            no_idle = (ph == 3);
            stamp = 0;
            n = 0;
            while (n < 200) begin
                // One long receiver hold-off while items keep coming.
                if (ph == 1 && n >= 40 && !held) begin
                    hold_req = 1'b1;
                    held = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    send_item(acnm_pkg::CMD_FRAME, 4'($urandom), 16'(stamp), 16'($urandom),
                              1'($urandom));
                    stamp = 0;
                    n++;
                end else if (pick < 16) begin
                    send_item(acnm_pkg::CMD_DELTA, 4'($urandom), 16'(stamp), rand_delta(),
                              1'($urandom));
                    n++;
                end else begin
                    k = $urandom_range(1, 4);
                    repeat (k) begin
                        ch = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                           : 4'($urandom_range(0, 10));
                        k--;
                        send_item(acnm_pkg::CMD_DELTA, ch, 16'(stamp), rand_delta(), k == 0);
                        n++;
                    end
                    stamp += ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20000)
                                                         : $urandom_range(1, 300);
                    if (stamp > 17'hFFFF) begin
                        send_item(acnm_pkg::CMD_FRAME, 4'd0, 16'hFFFF, 16'd0, 1'b0);
                        stamp = 0;
                        n++;
                    end
                end
            end
            wait_drained();
        end

        $display("Sent %0d items over 8 register settings; checked %0d mix and %0d frame results.",
                 items_sent, mix_seen, frame_seen);
        $display("Covered level and pending saturation, mono and stereo, gain extremes %s",
                 "and a long output stall.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
